// ===== rtl/key_pair_strength_table_macros.svh =====
// Assertion macros of the verification file of the key pair strength table.
// Depends on nothing; included by the checker module.
`ifndef KEY_PAIR_STRENGTH_TABLE_MACROS_SVH
`define KEY_PAIR_STRENGTH_TABLE_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define KPST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under a synchronous reset.
`define KPST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kpst_pkg.sv =====
// Shared types and constants of the key pair strength table.
// Depends on nothing; used by the store, the top level and the checker.
`default_nettype none

package kpst_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_LEARN     = 2'd0;
  localparam logic [1:0] CMD_REINFORCE = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;
  localparam logic [1:0] CMD_DECAY     = 2'd3;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Configuration register indexes.
  localparam logic REG_LEARN_RATE     = 1'b0;
  localparam logic REG_REINFORCE_RATE = 1'b1;

  // Q1.16 one and register reset values.
  localparam logic [16:0] ONE_Q16             = 17'h10000;
  localparam logic [16:0] LEARN_RATE_RESET    = 17'd6554;
  localparam logic [16:0] REINFORCE_RATE_RESET = 17'd13107;

  // One data memory entry.
  typedef struct packed {
    logic [31:0] total;
    logic [16:0] strength;
  } entry_t;

  // Write enables from the sequencer to the store.
  typedef struct packed {
    logic key_we;
    logic data_we;
  } store_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/kpst_if.sv =====
// Valid/ready channel interfaces for the items and results of the table.
// Depends on nothing.
`default_nettype none

interface kpst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        first_key;
  logic [31:0]        second_key;
  logic [15:0]        occurrence_increment;
  logic signed [15:0] outcome;
  logic [16:0]        scale_factor;

  modport source (output valid, command, first_key, second_key, occurrence_increment,
                  outcome, scale_factor, input ready);
  modport sink (input valid, command, first_key, second_key, occurrence_increment,
                outcome, scale_factor, output ready);
endinterface

interface kpst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] strength;
  logic [10:0] entries_used;

  modport source (output valid, status, strength, entries_used, input ready);
  modport sink (input valid, status, strength, entries_used, output ready);
endinterface

`default_nettype wire

// ===== rtl/kpst_store.sv =====
// Key memory and strength/total memory of the table, each with one write port
// and one registered read port. Depends on kpst_pkg.
`default_nettype none

module kpst_store #(
  parameter int AW       = 10,
  parameter int KEY_BITS = 32
) (
  input  wire                        clk,
  input  wire kpst_pkg::store_ctl_t  ctl,
  input  wire  [AW-1:0]              key_waddr,
  input  wire  [2*KEY_BITS-1:0]      key_wdata,
  input  wire  [AW-1:0]              key_raddr,
  output logic [2*KEY_BITS-1:0]      key_rdata,
  input  wire  [AW-1:0]              data_waddr,
  input  wire kpst_pkg::entry_t      data_wdata,
  input  wire  [AW-1:0]              data_raddr,
  output kpst_pkg::entry_t           data_rdata
);
  import kpst_pkg::*;

  logic [2*KEY_BITS-1:0] key_mem [0:(1<<AW)-1];
  entry_t                data_mem [0:(1<<AW)-1];

  // Key pairs: written on append, read during the search.
  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[key_raddr];
  end

  // Strengths and totals: read, modified and written back by the sequencer.
  always_ff @(posedge clk) begin
    if (ctl.data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rdata <= data_mem[data_raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/key_pair_strength_table.sv =====
// Key pair strength table: one item is taken at a time and gives one result. A search
// reads one stored key pair per cycle from the key memory. A learn steps the strength
// once per co-occurrence (stopping early once the strength reaches one or the learn
// rate leaves it unchanged). With a scale factor of at most one, decay sweeps the data
// memory at one entry per cycle. A result left waiting in the output register holds
// the next result, and the block, in its done state.
// The memories need no clearing after reset; only entries below the pair count are read.
`default_nettype none

module key_pair_strength_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [16:0] cfg_data,
  kpst_in_if.sink     items,
  kpst_out_if.source  results
);
  import kpst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_DATA   = 4'd3;
  localparam logic [3:0] S_UPD    = 4'd4;
  localparam logic [3:0] S_LEARN  = 4'd5;
  localparam logic [3:0] S_RF     = 4'd6;
  localparam logic [3:0] S_WB     = 4'd7;
  localparam logic [3:0] S_DECAY  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]          state;
  logic [16:0]         learn_rate;
  logic [16:0]         reinforce_rate;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rd_idx;
  logic                p_valid;
  logic [AW-1:0]       p_idx;
  logic [AW-1:0]       slot;
  logic [1:0]          cmd_q;
  logic [KEY_BITS-1:0] ka_q;
  logic [KEY_BITS-1:0] kb_q;
  logic [15:0]         inc_q;
  logic [15:0]         oraw_q;
  logic [16:0]         factor_q;
  logic [16:0]         cur;
  logic [31:0]         tot;
  logic [16:0]         gap;
  logic [31:0]         p1;
  logic [1:0]          res_status;
  logic [16:0]         res_strength;
  logic [10:0]         res_used;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [16:0]         out_strength;
  logic [10:0]         out_used;

  store_ctl_t            ctl;
  logic [2*KEY_BITS-1:0] key_rdata;
  entry_t                data_rdata;
  entry_t                data_wdata;
  logic [AW-1:0]         data_raddr;
  logic [AW-1:0]         data_waddr;

  logic        key_hit;
  logic        search_end;
  logic [16:0] keep;
  logic [16:0] rate;
  logic [15:0] mag;
  logic [33:0] gap_prod;
  logic [32:0] p1_prod;
  logic [16:0] rf_op;
  logic [48:0] rf_prod;
  logic [20:0] rf_d;
  logic [20:0] rf_sum;
  logic [16:0] rf_new;
  logic [33:0] decay_prod;
  logic [32:0] tot_sum;

  kpst_store #(.AW(AW), .KEY_BITS(KEY_BITS)) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .key_waddr  (count[AW-1:0]),
    .key_wdata  ({ka_q, kb_q}),
    .key_raddr  (rd_idx[AW-1:0]),
    .key_rdata  (key_rdata),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .data_raddr (data_raddr),
    .data_rdata (data_rdata)
  );

  // Search compare and end of the stored range.
  assign key_hit    = p_valid && (key_rdata == {ka_q, kb_q});
  assign search_end = !p_valid && (rd_idx == count);

  // Rates above one act as one.
  assign keep = ONE_Q16 - ((learn_rate > ONE_Q16) ? ONE_Q16 : learn_rate);
  assign rate = (reinforce_rate > ONE_Q16) ? ONE_Q16 : reinforce_rate;
  assign mag  = oraw_q[15] ? 16'(ONE_Q16 - {1'b0, oraw_q}) : oraw_q;

  // One moving-average step of the gap per cycle.
  assign gap_prod = 34'(gap) * 34'(keep);
  assign p1_prod  = 33'(rate) * 33'(mag);

  // Reinforce: second product against the gap or the strength, then clamp.
  assign rf_op   = oraw_q[15] ? cur : (ONE_Q16 - cur);
  assign rf_prod = 49'(p1) * 49'(rf_op);
  assign rf_d    = rf_prod[48:28];
  assign rf_sum  = 21'(cur) + rf_d;
  always_comb begin
    if (oraw_q[15]) begin
      rf_new = (rf_d > 21'(cur)) ? 17'd0 : (cur - rf_d[16:0]);
    end else begin
      rf_new = (rf_sum > 21'(ONE_Q16)) ? ONE_Q16 : rf_sum[16:0];
    end
  end

  assign decay_prod = 34'(data_rdata.strength) * 34'(factor_q);
  assign tot_sum    = 33'(tot) + 33'(inc_q);

  // Memory port control.
  assign data_raddr = (state == S_DECAY) ? rd_idx[AW-1:0] : slot;
  assign data_waddr = (state == S_WB) ? slot : p_idx;
  always_comb begin
    if (state == S_WB) begin
      data_wdata.total    = tot;
      data_wdata.strength = cur;
    end else begin
      data_wdata.total    = data_rdata.total;
      data_wdata.strength = decay_prod[32:16];
    end
  end
  assign ctl.data_we = (state == S_WB) || ((state == S_DECAY) && p_valid);
  assign ctl.key_we  = (state == S_SEARCH) && !key_hit && search_end &&
                       (cmd_q != CMD_QUERY) && (count < CW'(TABLE_DEPTH));

  assign items.ready = (state == S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate     <= LEARN_RATE_RESET;
      reinforce_rate <= REINFORCE_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE:     learn_rate     <= cfg_data;
        REG_REINFORCE_RATE: reinforce_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: search, read, modify, write back, sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      p_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            cmd_q    <= items.command;
            ka_q     <= KEY_BITS'(items.first_key);
            kb_q     <= KEY_BITS'(items.second_key);
            inc_q    <= items.occurrence_increment;
            oraw_q   <= items.outcome;
            factor_q <= items.scale_factor;
            rd_idx   <= '0;
            p_valid  <= 1'b0;
            if (items.command == CMD_DECAY) begin
              if (items.scale_factor > ONE_Q16) begin
                res_status   <= ST_OK;
                res_strength <= '0;
                res_used     <= '0;
                state        <= S_DONE;
              end else begin
                state <= S_DECAY;
              end
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (rd_idx < count) begin
            rd_idx  <= rd_idx + CW'(1);
            p_valid <= 1'b1;
            p_idx   <= rd_idx[AW-1:0];
          end else begin
            p_valid <= 1'b0;
          end
          if (key_hit) begin
            slot  <= p_idx;
            state <= S_READ;
          end else if (search_end) begin
            if (cmd_q == CMD_QUERY) begin
              res_status   <= ST_NOT_FOUND;
              res_strength <= '0;
              res_used     <= '0;
              state        <= S_DONE;
            end else if (count >= CW'(TABLE_DEPTH)) begin
              res_status   <= ST_FULL;
              res_strength <= '0;
              res_used     <= '0;
              state        <= S_DONE;
            end else begin
              // Append a new pair at strength zero.
              slot  <= count[AW-1:0];
              count <= count + CW'(1);
              cur   <= '0;
              tot   <= '0;
              state <= S_UPD;
            end
          end
        end
        S_READ: begin
          state <= S_DATA;
        end
        S_DATA: begin
          cur <= data_rdata.strength;
          tot <= data_rdata.total;
          if (cmd_q == CMD_QUERY) begin
            res_status   <= ST_OK;
            res_strength <= data_rdata.strength;
            res_used     <= '0;
            state        <= S_DONE;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (cmd_q == CMD_LEARN) begin
            tot   <= tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
            gap   <= ONE_Q16 - cur;
            state <= S_LEARN;
          end else if (oraw_q == 16'd0) begin
            state <= S_WB;
          end else begin
            p1    <= p1_prod[31:0];
            state <= S_RF;
          end
        end
        S_LEARN: begin
          if ((inc_q == 16'd0) || (gap == 17'd0) || (keep == ONE_Q16)) begin
            cur   <= ONE_Q16 - gap;
            state <= S_WB;
          end else begin
            gap   <= gap_prod[32:16];
            inc_q <= inc_q - 16'd1;
          end
        end
        S_RF: begin
          cur   <= rf_new;
          state <= S_WB;
        end
        S_WB: begin
          res_status   <= ST_OK;
          res_strength <= cur;
          res_used     <= '0;
          state        <= S_DONE;
        end
        S_DECAY: begin
          if (rd_idx < count) begin
            rd_idx  <= rd_idx + CW'(1);
            p_valid <= 1'b1;
            p_idx   <= rd_idx[AW-1:0];
          end else begin
            p_valid <= 1'b0;
          end
          if (search_end) begin
            res_status   <= ST_OK;
            res_strength <= '0;
            res_used     <= 11'(count);
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the result stage is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || results.ready)) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || results.ready)) begin
      out_status   <= res_status;
      out_strength <= res_strength;
      out_used     <= res_used;
    end
  end

  assign results.valid        = out_valid;
  assign results.status       = out_status;
  assign results.strength     = out_strength;
  assign results.entries_used = out_used;

endmodule

`default_nettype wire

// ===== rtl/kpst_checker.sv =====
// Port-level checks of the key pair strength table and their bind to the top level.
// Depends on kpst_pkg and key_pair_strength_table_macros.svh.
`default_nettype none

`include "key_pair_strength_table_macros.svh"

module kpst_port_checks (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire [16:0] out_strength,
  input wire [10:0] out_used
);
  import kpst_pkg::*;

  // A waiting result stays until it is taken.
  `KPST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  // One item at a time: after an item is taken the block is busy.
  `KPST_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "item taken while busy")
  // Strengths never exceed one.
  `KPST_ASSERT_NOW(a_range, clk, rst, out_valid, out_strength <= ONE_Q16, "strength above one")
  // Error results carry no strength and no count.
  `KPST_ASSERT_NOW(a_err, clk, rst, out_valid && (out_status != ST_OK),
                   (out_strength == 17'd0) && (out_used == 11'd0), "error result not zero")

endmodule

bind key_pair_strength_table kpst_port_checks u_kpst_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_status   (results.status),
  .out_strength (results.strength),
  .out_used     (results.entries_used)
);

`default_nettype wire
